@@ src/vpci_pkg.sv @@
package vpci_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_IRQ   = 2'd2,
    ACT_RSVD  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    RC_OK     = 3'd0,
    RC_UNSUP  = 3'd1,
    RC_BADQ   = 3'd2,
    RC_WIDTH  = 3'd3,
    RC_RANGE  = 3'd4,
    RC_ALIGN  = 3'd5
  } rc_e;

  typedef enum logic [1:0] {
    CFG_OFFERED  = 2'd0,
    CFG_QCOUNT   = 2'd1,
    CFG_DCFG_LEN = 2'd2
  } cfg_idx_e;

  localparam logic [2:0] BAR_CFG    = 3'd0;
  localparam logic [2:0] BAR_NOTIFY = 3'd1;

  localparam logic [2:0] W_BYTE = 3'd1;
  localparam logic [2:0] W_HALF = 3'd2;
  localparam logic [2:0] W_WORD = 3'd4;

  localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h000;
  localparam logic [11:0] OFF_DEV_FEAT     = 12'h004;
  localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h008;
  localparam logic [11:0] OFF_DRV_FEAT     = 12'h00c;
  localparam logic [11:0] OFF_MSIX_CFG     = 12'h010;
  localparam logic [11:0] OFF_NUM_QUEUES   = 12'h012;
  localparam logic [11:0] OFF_DEV_STATUS   = 12'h014;
  localparam logic [11:0] OFF_CFG_GEN      = 12'h015;
  localparam logic [11:0] OFF_QUEUE_SEL    = 12'h016;
  localparam logic [11:0] OFF_QUEUE_SIZE   = 12'h018;
  localparam logic [11:0] OFF_QUEUE_MSIX   = 12'h01a;
  localparam logic [11:0] OFF_QUEUE_EN     = 12'h01c;
  localparam logic [11:0] OFF_QUEUE_NOTIFY = 12'h01e;
  localparam logic [11:0] OFF_RING_FIRST   = 12'h020;
  localparam logic [11:0] OFF_RING_LAST    = 12'h034;
  localparam logic [11:0] ISR_OFFSET       = 12'h038;
  localparam logic [11:0] DEVCFG_BASE      = 12'h03c;

  localparam int unsigned DRIVER_OK_BIT = 2;
  localparam logic [31:0] FEAT_VERSION_1 = 32'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  bar_index;
    logic [11:0] byte_offset;
    logic [2:0]  width_bytes;
    logic [31:0] write_value;
    logic [7:0]  irq_bits;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [2:0]  result_code;
    logic        ready_pulse;
    logic [31:0] agreed_features;
    logic        cfg_changed_pulse;
    logic [5:0]  cfg_changed_offset;
    logic        doorbell_pulse;
    logic [9:0]  doorbell_queue;
    logic        irq_request;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offered_features;
    logic [4:0]  queue_count;
    logic [6:0]  device_cfg_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] dev_feat_select;
    logic [31:0] drv_feat_select;
    logic [31:0] drv_features;
    logic [7:0]  dev_status;
    logic [15:0] queue_select;
    logic [7:0]  isr_flags;
  } state_t;

  typedef struct packed {
    logic        qsz_we;
    logic [15:0] qsz_data;
    logic        ring_we;
    logic [31:0] ring_data;
    logic        dcfg_we;
    logic [31:0] dcfg_data;
  } mem_wr_t;

endpackage

@@ src/vpci_req_if.sv @@
interface vpci_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  bar_index;
  logic [11:0] byte_offset;
  logic [2:0]  width_bytes;
  logic [31:0] write_value;
  logic [7:0]  irq_bits;

  modport source (
    output valid, action, bar_index, byte_offset, width_bytes, write_value, irq_bits,
    input  ready
  );
  modport sink (
    input  valid, action, bar_index, byte_offset, width_bytes, write_value, irq_bits,
    output ready
  );
endinterface

@@ src/vpci_rsp_if.sv @@
interface vpci_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [2:0]  result_code;
  logic        ready_pulse;
  logic [31:0] agreed_features;
  logic        cfg_changed_pulse;
  logic [5:0]  cfg_changed_offset;
  logic        doorbell_pulse;
  logic [9:0]  doorbell_queue;
  logic        irq_request;

  modport source (
    output valid, read_value, result_code, ready_pulse, agreed_features,
           cfg_changed_pulse, cfg_changed_offset, doorbell_pulse, doorbell_queue,
           irq_request,
    input  ready
  );
  modport sink (
    input  valid, read_value, result_code, ready_pulse, agreed_features,
           cfg_changed_pulse, cfg_changed_offset, doorbell_pulse, doorbell_queue,
           irq_request,
    output ready
  );
endinterface

@@ src/virtio_pci_transport_registers_top.sv @@
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    action, bar_index, byte_offset, width_bytes,
//                               write_value, irq_bits
// rsp_o     out  valid/ready    read_value, result_code, pulses, irq_request
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
// One transaction per cycle sustained while results are taken. At accept the
// queue-size, ring-word and device-config memories are read into the execute
// stage, which then executes, writes back and loads the output register.
// After reset a clearing pass zeroes all three memories, one entry per cycle;
// no transaction is accepted until it is done. A stalled result holds the
// execute stage, and outside the clearing pass input ready drops only when
// both the stage and the output are full and the output is not taken.
module virtio_pci_transport_registers_top #(
  parameter int unsigned MAX_QUEUES    = 16,
  parameter int unsigned DEV_CFG_BYTES = 64,
  parameter int unsigned NOTIFY_STRIDE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  vpci_req_if.sink    req_i,
  vpci_rsp_if.source  rsp_o
);
  import vpci_pkg::*;

  localparam int unsigned RING_DEPTH = MAX_QUEUES * 6;
  localparam int unsigned CFG_ROWS   = (DEV_CFG_BYTES + 3) / 4;
  localparam int unsigned QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int unsigned RW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (CFG_ROWS > 1) ? $clog2(CFG_ROWS) : 1;
  localparam int unsigned CLR_DEPTH = (RING_DEPTH > CFG_ROWS) ? RING_DEPTH : CFG_ROWS;
  localparam int unsigned KW = $clog2(CLR_DEPTH);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offered_features  <= '0;
      cfg_q.queue_count       <= 5'd1;
      cfg_q.device_cfg_length <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFERED:  cfg_q.offered_features  <= cfg_wdata_i;
        CFG_QCOUNT:   cfg_q.queue_count       <= cfg_wdata_i[4:0];
        CFG_DCFG_LEN: cfg_q.device_cfg_length <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clearing_q, clearing_d;
  logic [KW-1:0] clr_q, clr_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      if (32'(clr_q) == CLR_DEPTH - 1) clearing_d = 1'b0;
      else clr_d = clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  // handshake and pipeline control
  logic   s1_valid_q, s1_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   s1_fire;
  logic   accept;
  logic   in_ready;
  req_t   s1_req_q;
  req_t   req_new;
  state_t st_q, st_d;
  rsp_t   rsp_d, rsp_q;
  mem_wr_t wr;

  assign s1_fire  = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready = !clearing_q && (!s1_valid_q || s1_fire);
  assign accept   = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  assign req_new = '{action:      req_i.action,
                     bar_index:   req_i.bar_index,
                     byte_offset: req_i.byte_offset,
                     width_bytes: req_i.width_bytes,
                     write_value: req_i.write_value,
                     irq_bits:    req_i.irq_bits};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_fire) out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) st_q <= st_d;
    end
  end

  // read addresses use the queue select as left by the executing transaction
  logic [15:0]   qsel_fwd;
  logic [11:0]   c_new;
  logic [QW-1:0] qsz_raddr, s1_qsz_addr_q;
  logic [RW-1:0] ring_raddr, s1_ring_addr_q;
  logic [CW-1:0] dcfg_raddr, s1_dcfg_row_q;

  assign qsel_fwd   = s1_fire ? st_d.queue_select : st_q.queue_select;
  assign c_new      = req_i.byte_offset - DEVCFG_BASE;
  assign qsz_raddr  = qsel_fwd[QW-1:0];
  assign ring_raddr = RW'({{(RW-QW){1'b0}}, qsel_fwd[QW-1:0]} * RW'(6)
                          + RW'(req_i.byte_offset[4:2]));
  assign dcfg_raddr = c_new[CW+1:2];

  // forward a write-back that lands on the entry read in the same cycle
  logic        qsz_hit_q, ring_hit_q, dcfg_hit_q;
  logic [15:0] qsz_byp_q;
  logic [31:0] ring_byp_q, dcfg_byp_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q       <= req_new;
      s1_qsz_addr_q  <= qsz_raddr;
      s1_ring_addr_q <= ring_raddr;
      s1_dcfg_row_q  <= dcfg_raddr;
      qsz_hit_q      <= s1_fire && wr.qsz_we && (qsz_raddr == s1_qsz_addr_q);
      ring_hit_q     <= s1_fire && wr.ring_we && (ring_raddr == s1_ring_addr_q);
      dcfg_hit_q     <= s1_fire && wr.dcfg_we && (dcfg_raddr == s1_dcfg_row_q);
      qsz_byp_q      <= wr.qsz_data;
      ring_byp_q     <= wr.ring_data;
      dcfg_byp_q     <= wr.dcfg_data;
    end
  end

  // memories: clearing pass owns the write port until done
  logic          qsz_we, ring_we, dcfg_we;
  logic [QW-1:0] qsz_waddr;
  logic [RW-1:0] ring_waddr;
  logic [CW-1:0] dcfg_waddr;
  logic [15:0]   qsz_wdata, qsz_mem_rd, qsz_rd;
  logic [31:0]   ring_wdata, ring_mem_rd, ring_rd;
  logic [31:0]   dcfg_wdata, dcfg_mem_rd, dcfg_rd;

  always_comb begin
    if (clearing_q) begin
      qsz_we     = 32'(clr_q) < MAX_QUEUES;
      ring_we    = 32'(clr_q) < RING_DEPTH;
      dcfg_we    = 32'(clr_q) < CFG_ROWS;
      qsz_waddr  = clr_q[QW-1:0];
      ring_waddr = clr_q[RW-1:0];
      dcfg_waddr = clr_q[CW-1:0];
      qsz_wdata  = '0;
      ring_wdata = '0;
      dcfg_wdata = '0;
    end else begin
      qsz_we     = s1_fire && wr.qsz_we;
      ring_we    = s1_fire && wr.ring_we;
      dcfg_we    = s1_fire && wr.dcfg_we;
      qsz_waddr  = s1_qsz_addr_q;
      ring_waddr = s1_ring_addr_q;
      dcfg_waddr = s1_dcfg_row_q;
      qsz_wdata  = wr.qsz_data;
      ring_wdata = wr.ring_data;
      dcfg_wdata = wr.dcfg_data;
    end
  end

  vpci_ram #(.WIDTH(16), .DEPTH(MAX_QUEUES)) u_qsz_ram (
    .clk_i   (clk_i),
    .we_i    (qsz_we),
    .waddr_i (qsz_waddr),
    .wdata_i (qsz_wdata),
    .re_i    (accept),
    .raddr_i (qsz_raddr),
    .rdata_o (qsz_mem_rd)
  );

  vpci_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (accept),
    .raddr_i (ring_raddr),
    .rdata_o (ring_mem_rd)
  );

  vpci_ram #(.WIDTH(32), .DEPTH(CFG_ROWS)) u_dcfg_ram (
    .clk_i   (clk_i),
    .we_i    (dcfg_we),
    .waddr_i (dcfg_waddr),
    .wdata_i (dcfg_wdata),
    .re_i    (accept),
    .raddr_i (dcfg_raddr),
    .rdata_o (dcfg_mem_rd)
  );

  assign qsz_rd  = qsz_hit_q  ? qsz_byp_q  : qsz_mem_rd;
  assign ring_rd = ring_hit_q ? ring_byp_q : ring_mem_rd;
  assign dcfg_rd = dcfg_hit_q ? dcfg_byp_q : dcfg_mem_rd;

  // execute stage: decode, modify, write back
  vpci_exec #(
    .MAX_QUEUES    (MAX_QUEUES),
    .DEV_CFG_BYTES (DEV_CFG_BYTES),
    .NOTIFY_STRIDE (NOTIFY_STRIDE)
  ) u_exec (
    .req_i      (s1_req_q),
    .cfg_i      (cfg_q),
    .st_i       (st_q),
    .qsz_rd_i   (qsz_rd),
    .ring_rd_i  (ring_rd),
    .dcfg_rd_i  (dcfg_rd),
    .dcfg_row_i (s1_dcfg_row_q),
    .st_o       (st_d),
    .rsp_o      (rsp_d),
    .wr_o       (wr)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_fire) rsp_q <= rsp_d;
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.read_value         = rsp_q.read_value;
  assign rsp_o.result_code        = rsp_q.result_code;
  assign rsp_o.ready_pulse        = rsp_q.ready_pulse;
  assign rsp_o.agreed_features    = rsp_q.agreed_features;
  assign rsp_o.cfg_changed_pulse  = rsp_q.cfg_changed_pulse;
  assign rsp_o.cfg_changed_offset = rsp_q.cfg_changed_offset;
  assign rsp_o.doorbell_pulse     = rsp_q.doorbell_pulse;
  assign rsp_o.doorbell_queue     = rsp_q.doorbell_queue;
  assign rsp_o.irq_request        = rsp_q.irq_request;

  // assertions
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !clearing_q)
    else $error("transaction accepted during clearing pass");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $onehot0({rsp_o.ready_pulse, rsp_o.cfg_changed_pulse,
                              rsp_o.doorbell_pulse, rsp_o.irq_request}))
    else $error("more than one event pulse in a result");

  a_pulse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.ready_pulse || rsp_o.cfg_changed_pulse || rsp_o.doorbell_pulse))
    |-> (rsp_o.result_code == RC_OK))
    else $error("event pulse with failing result code");

  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted transaction lost before execute");

endmodule

@@ src/vpci_ram.sv @@
module vpci_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write; the caller forwards same-entry hits
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/vpci_exec.sv @@
module vpci_exec #(
  parameter int unsigned MAX_QUEUES    = 16,
  parameter int unsigned DEV_CFG_BYTES = 64,
  parameter int unsigned NOTIFY_STRIDE = 4,
  localparam int unsigned CFG_ROWS = (DEV_CFG_BYTES + 3) / 4,
  localparam int unsigned CW = (CFG_ROWS > 1) ? $clog2(CFG_ROWS) : 1
) (
  input  vpci_pkg::req_t   req_i,
  input  vpci_pkg::cfg_t   cfg_i,
  input  vpci_pkg::state_t st_i,
  input  logic [15:0]      qsz_rd_i,
  input  logic [31:0]      ring_rd_i,
  input  logic [31:0]      dcfg_rd_i,
  input  logic [CW-1:0]    dcfg_row_i,
  output vpci_pkg::state_t st_o,
  output vpci_pkg::rsp_t   rsp_o,
  output vpci_pkg::mem_wr_t wr_o
);
  import vpci_pkg::*;

  // reciprocal of the notify stride, exact for every 12-bit offset
  localparam logic [24:0] NS_RECIP = 25'((2**24 + NOTIFY_STRIDE - 1) / NOTIFY_STRIDE);

  logic [10:0] eff_q;
  logic [12:0] eff_len;
  logic        q_ok;
  logic [11:0] off;
  logic [11:0] c_off;
  logic        in_dcfg;
  logic        in_ring;
  logic        w_ok;
  logic [2:0]  w;
  logic [31:0] v;
  logic [3:0]  be;
  logic [31:0] wd;
  logic [31:0] merged;
  rc_e         rc;
  logic [31:0] val;
  logic [36:0] ns_prod;
  logic [11:0] ns_quo;
  logic [11:0] ns_rem;

  always_comb begin
    eff_q   = (32'(cfg_i.queue_count) < MAX_QUEUES) ? 11'(cfg_i.queue_count)
                                                    : 11'(MAX_QUEUES);
    eff_len = (32'(cfg_i.device_cfg_length) < DEV_CFG_BYTES)
              ? 13'(cfg_i.device_cfg_length) : 13'(DEV_CFG_BYTES);
    q_ok    = st_i.queue_select < 16'(eff_q);
    off     = req_i.byte_offset;
    c_off   = off - DEVCFG_BASE;
    in_dcfg = (off >= DEVCFG_BASE) && ({1'b0, c_off} < eff_len);
    in_ring = (off >= OFF_RING_FIRST) && (off <= OFF_RING_LAST);
    w       = req_i.width_bytes;
    v       = req_i.write_value;
    w_ok    = (w == W_BYTE) || (w == W_HALF) || (w == W_WORD);

    // split the notify offset into doorbell index and remainder
    ns_prod = 37'(off) * 37'(NS_RECIP);
    ns_quo  = ns_prod[35:24];
    ns_rem  = off - 12'(32'(ns_quo) * NOTIFY_STRIDE);

    // place write bytes inside the 4-byte row
    if (w == W_BYTE) begin
      be = 4'b0001 << c_off[1:0];
      wd = {4{v[7:0]}};
    end else if (w == W_HALF) begin
      be = c_off[1] ? 4'b1100 : 4'b0011;
      wd = {2{v[15:0]}};
    end else begin
      be = 4'b1111;
      wd = v;
    end
    for (int k = 0; k < 4; k++) begin
      if (be[k] && ((32'(dcfg_row_i) * 4 + k) < DEV_CFG_BYTES)) begin
        merged[8*k +: 8] = wd[8*k +: 8];
      end else begin
        merged[8*k +: 8] = dcfg_rd_i[8*k +: 8];
      end
    end

    st_o  = st_i;
    rsp_o = '0;
    wr_o  = '0;
    wr_o.qsz_data  = v[15:0];
    wr_o.ring_data = v;
    wr_o.dcfg_data = merged;
    rc  = RC_UNSUP;
    val = '0;

    unique case (act_e'(req_i.action))
      ACT_READ: begin
        if (req_i.bar_index == BAR_CFG) begin
          if (off < ISR_OFFSET) begin
            if (in_ring) begin
              rc  = q_ok ? RC_OK : RC_BADQ;
              val = ring_rd_i;
            end else begin
              rc = RC_OK;
              case (off)
                OFF_DEV_FEAT_SEL: val = st_i.dev_feat_select;
                OFF_DEV_FEAT: begin
                  if (st_i.dev_feat_select == 32'd1) val = FEAT_VERSION_1;
                  else if (st_i.dev_feat_select != '0) val = '0;
                  else val = cfg_i.offered_features;
                end
                OFF_DRV_FEAT_SEL: val = st_i.drv_feat_select;
                OFF_DRV_FEAT: val = (st_i.drv_feat_select != '0) ? '0 : st_i.drv_features;
                OFF_MSIX_CFG, OFF_CFG_GEN, OFF_QUEUE_MSIX, OFF_QUEUE_EN: val = '0;
                OFF_NUM_QUEUES: val = 32'(cfg_i.queue_count);
                OFF_DEV_STATUS: val = 32'(st_i.dev_status);
                OFF_QUEUE_SEL: val = 32'(st_i.queue_select);
                OFF_QUEUE_SIZE: begin
                  rc  = q_ok ? RC_OK : RC_BADQ;
                  val = 32'(qsz_rd_i);
                end
                OFF_QUEUE_NOTIFY: begin
                  rc  = q_ok ? RC_OK : RC_BADQ;
                  val = 32'(st_i.queue_select);
                end
                default: rc = RC_UNSUP;
              endcase
            end
          end else if (off == ISR_OFFSET) begin
            rc  = RC_OK;
            val = 32'(st_i.isr_flags);
            st_o.isr_flags = '0;
          end else if (in_dcfg && w_ok) begin
            rc = RC_OK;
            if (w == W_BYTE) val = 32'(dcfg_rd_i >> (8 * c_off[1:0])) & 32'h0000_00ff;
            else if (w == W_HALF) val = 32'(dcfg_rd_i >> (16 * c_off[1])) & 32'h0000_ffff;
            else val = dcfg_rd_i;
          end
        end
      end
      ACT_WRITE: begin
        if (req_i.bar_index == BAR_CFG) begin
          if (off < ISR_OFFSET) begin
            if (in_ring) begin
              if (w != W_WORD) rc = RC_WIDTH;
              else if (!q_ok) rc = RC_BADQ;
              else begin
                rc = RC_OK;
                wr_o.ring_we = 1'b1;
              end
            end else begin
              case (off)
                OFF_DEV_FEAT_SEL: begin
                  rc = (w == W_WORD) ? RC_OK : RC_WIDTH;
                  if (w == W_WORD) st_o.dev_feat_select = v;
                end
                OFF_DRV_FEAT_SEL: begin
                  rc = (w == W_WORD) ? RC_OK : RC_WIDTH;
                  if (w == W_WORD) st_o.drv_feat_select = v;
                end
                OFF_DRV_FEAT: begin
                  rc = (w == W_WORD) ? RC_OK : RC_WIDTH;
                  if ((w == W_WORD) && (st_i.drv_feat_select == '0)) st_o.drv_features = v;
                end
                OFF_DEV_STATUS: begin
                  if (w != W_BYTE) rc = RC_WIDTH;
                  else begin
                    rc = RC_OK;
                    st_o.dev_status = v[7:0];
                    if (v[DRIVER_OK_BIT]) begin
                      rsp_o.ready_pulse     = 1'b1;
                      rsp_o.agreed_features = cfg_i.offered_features & st_i.drv_features;
                    end
                  end
                end
                OFF_QUEUE_SEL: begin
                  if (w != W_HALF) rc = RC_WIDTH;
                  else if (v[15:0] >= 16'(eff_q)) rc = RC_RANGE;
                  else begin
                    rc = RC_OK;
                    st_o.queue_select = v[15:0];
                  end
                end
                OFF_QUEUE_SIZE: begin
                  if (w != W_HALF) rc = RC_WIDTH;
                  else if (!q_ok) rc = RC_BADQ;
                  else begin
                    rc = RC_OK;
                    wr_o.qsz_we = 1'b1;
                  end
                end
                OFF_MSIX_CFG, OFF_QUEUE_MSIX, OFF_QUEUE_EN: rc = RC_OK;
                default: rc = RC_UNSUP;
              endcase
            end
          end else if (in_dcfg && w_ok) begin
            rc = RC_OK;
            wr_o.dcfg_we = 1'b1;
            rsp_o.cfg_changed_pulse  = 1'b1;
            rsp_o.cfg_changed_offset = c_off[5:0];
          end
        end else if (req_i.bar_index == BAR_NOTIFY) begin
          if (ns_rem != '0) rc = RC_ALIGN;
          else begin
            rc = RC_OK;
            rsp_o.doorbell_pulse = 1'b1;
            rsp_o.doorbell_queue = ns_quo[9:0];
          end
        end
      end
      ACT_IRQ: begin
        rc = RC_OK;
        st_o.isr_flags = st_i.isr_flags | req_i.irq_bits;
        rsp_o.irq_request = (st_i.isr_flags | req_i.irq_bits) != '0;
      end
      ACT_RSVD: rc = RC_UNSUP;
    endcase

    rsp_o.result_code = rc;
    rsp_o.read_value  = (rc == RC_OK) ? val : '0;
  end

endmodule
